FILE: sv/fhtc_pkg.sv
// ----------------------------------------------------------------------------
// fhtc_pkg
// Shared types, constants and helpers of the fan heater tick controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fhtc_pkg;

  localparam int unsigned TASK_TICKS       = 500;
  localparam int unsigned SWING_FLIP_TICKS = 2000;

  localparam int unsigned TaskCntW  = $clog2(TASK_TICKS + 1);
  localparam int unsigned FlipCntW  = $clog2(SWING_FLIP_TICKS + 1);

  localparam logic [TaskCntW-1:0] TaskLast = TaskCntW'(TASK_TICKS);
  localparam logic [FlipCntW-1:0] FlipLast = FlipCntW'(SWING_FLIP_TICKS);

  localparam logic [6:0] PwmLast      = 7'd99;
  localparam logic [4:0] SwingLast    = 5'd20;
  localparam logic [6:0] DutyMax      = 7'd99;
  localparam logic [6:0] DutyReset    = 7'd40;
  localparam logic [6:0] TimerCeiling = 7'd90;
  localparam logic [6:0] TimerStep    = 7'd10;
  localparam logic [7:0] BeepHigh     = 8'd50;
  localparam logic [7:0] BeepLow      = 8'd100;

  localparam logic signed [7:0] AlarmHighReset = 8'sd70;
  localparam logic signed [7:0] AlarmLowReset  = 8'sd0;
  localparam logic signed [7:0] BandOneReset   = 8'sd20;
  localparam logic signed [7:0] BandTwoReset   = 8'sd30;
  localparam logic signed [7:0] BandThreeReset = 8'sd40;

  typedef enum logic [2:0] {
    REG_ALARM_HIGH = 3'd0,
    REG_ALARM_LOW  = 3'd1,
    REG_BAND_ONE   = 3'd2,
    REG_BAND_TWO   = 3'd3,
    REG_BAND_THREE = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    KEY_GEAR1     = 4'd0,
    KEY_GEAR2     = 4'd1,
    KEY_GEAR3     = 4'd2,
    KEY_GEAR4     = 4'd3,
    KEY_SPEED1    = 4'd4,
    KEY_SPEED2    = 4'd5,
    KEY_SPEED3    = 4'd6,
    KEY_TIMER_ADD = 4'd7,
    KEY_SWING     = 4'd8,
    KEY_START     = 4'd9,
    KEY_STOP      = 4'd10,
    KEY_AUTO      = 4'd11
  } key_e;

  typedef enum logic [1:0] {
    ALARM_NONE = 2'd0,
    ALARM_HIGH = 2'd1,
    ALARM_LOW  = 2'd2
  } alarm_e;

  localparam logic OP_TICK = 1'b0;

  typedef struct packed {
    logic              running;
    logic signed [7:0] temperature_c;
    logic        [1:0] alarm_kind;
    logic        [6:0] minutes_left;
    logic        [1:0] speed_level;
    logic        [2:0] gear_level;
    logic              buzzer_drive;
    logic              swing_drive;
    logic              heater_drive;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  // Remainder by 20 of a value up to 127, by repeated compare and subtract.
  function automatic logic [4:0] mod20(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    for (int i = 0; i < 6; i++) begin
      if (r >= 7'd20) begin
        r = r - 7'd20;
      end
    end
    return r[4:0];
  endfunction

endpackage

FILE: sv/fan_heater_tick_controller.sv
// ----------------------------------------------------------------------------
// fan_heater_tick_controller
// Fan heater control: tick and key beats in, one status beat out per input.
//
// Each input beat is a 1 ms tick (tuser = 0) or a debounced key press
// (tuser = 1). Tick beats carry the sensor word; key beats carry the key code.
// For every accepted beat the block emits exactly one status beat with the
// pin levels, gear, speed, countdown, alarm, temperature and run flag as they
// stand after that beat. The update is combinational, so the status beat is
// valid in the cycle after acceptance and a new beat can be taken every cycle
// while the receiver is ready; the output register is the only storage between
// the channels. When the receiver stalls, the status beat holds and the input
// is taken again in the cycle the held beat leaves. Threshold registers are
// written through the cfg channel, which is always ready. Reset returns all
// state and thresholds to their defaults and leaves the output empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_heater_tick_controller import fhtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] key_code, [15:4] sensor_word
  input  logic [15:0]         s_axis_tdata,
  // [0] op
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] heater_drive, [1] swing_drive, [2] buzzer_drive, [5:3] gear_level,
  // [7:6] speed_level, [14:8] minutes_left, [16:15] alarm_kind,
  // [24:17] temperature_c, [25] running
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  logic    accept;
  logic    out_valid_q;
  result_t result_d, result_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  fhtc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .op_i          (s_axis_tuser[0]),
    .key_code_i    (s_axis_tdata[3:0]),
    .sensor_word_i (s_axis_tdata[15:4]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(result_q);

  a_accept_gives_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted beat produced no status beat");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(result_q))
    else $error("status beat changed while stalled");

  a_minutes_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> result_q.minutes_left <= 7'd99)
    else $error("countdown out of range");

  a_gear_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (result_q.gear_level >= 3'd1 && result_q.gear_level <= 3'd4))
    else $error("gear out of range");

  a_alarm_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> result_q.alarm_kind != 2'd3)
    else $error("invalid alarm code");

endmodule

FILE: sv/fhtc_core.sv
// ----------------------------------------------------------------------------
// fhtc_core
// Controller state, configuration registers and the per-beat update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhtc_core import fhtc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              op_i,
  input  logic       [3:0]  key_code_i,
  input  logic signed [11:0] sensor_word_i,
  input  logic              cfg_we_i,
  input  logic       [2:0]  cfg_index_i,
  input  logic       [7:0]  cfg_data_i,
  output result_t           result_o
);

  logic signed [7:0] high_q, low_q, b1_q, b2_q, b3_q;

  logic [6:0]          pwm_q, pwm_d;
  logic [4:0]          sph_q, sph_d;
  logic [FlipCntW-1:0] flip_q, flip_d;
  logic [1:0]          sduty_q, sduty_d;
  logic [TaskCntW-1:0] task_q, task_d;
  logic [1:0]          half_q, half_d;
  logic [6:0]          duty_q, duty_d;
  logic [2:0]          gear_q, gear_d;
  logic [1:0]          speed_q, speed_d;
  logic [6:0]          cd_q, cd_d;
  logic                started_q, started_d;
  logic                swon_q, swon_d;
  logic                auto_q, auto_d;
  logic                paused_q, paused_d;
  alarm_e              alarm_q, alarm_d;
  logic [7:0]          beep_q, beep_d;
  logic signed [7:0]   deg_q, deg_d;
  logic                heat_q, heat_d;
  logic                swp_q, swp_d;
  logic                buzz_q, buzz_d;

  logic [11:0]       mag12;
  logic [7:0]        mag8;
  logic signed [7:0] deg_new;

  assign mag12   = sensor_word_i[11] ? 12'(-sensor_word_i) : 12'(sensor_word_i);
  assign mag8    = mag12[11:4];
  assign deg_new = sensor_word_i[11] ? 8'(-mag8) : mag8;

  always_comb begin
    pwm_d     = pwm_q;
    sph_d     = sph_q;
    flip_d    = flip_q;
    sduty_d   = sduty_q;
    task_d    = task_q;
    half_d    = half_q;
    duty_d    = duty_q;
    gear_d    = gear_q;
    speed_d   = speed_q;
    cd_d      = cd_q;
    started_d = started_q;
    swon_d    = swon_q;
    auto_d    = auto_q;
    paused_d  = paused_q;
    alarm_d   = alarm_q;
    beep_d    = beep_q;
    deg_d     = deg_q;
    heat_d    = heat_q;
    swp_d     = swp_q;
    buzz_d    = buzz_q;

    if (op_i == OP_TICK) begin
      if (!paused_q) begin
        if (started_q) begin
          pwm_d  = (pwm_q < PwmLast) ? pwm_q + 7'd1 : 7'd0;
          heat_d = (pwm_d < duty_q) ? 1'b0 : 1'b1;
          sph_d  = (sph_q < SwingLast) ? sph_q + 5'd1 : 5'd0;
          swp_d  = (sph_d < {3'd0, sduty_q});
          if (swon_q) begin
            if (flip_q < FlipLast) begin
              flip_d = flip_q + FlipCntW'(1);
            end else begin
              flip_d  = '0;
              sduty_d = (sduty_q == 2'd1) ? 2'd2 : 2'd1;
            end
          end
        end else begin
          swon_d = 1'b0;
          heat_d = 1'b1;
        end
      end

      if (task_q < TaskLast) begin
        task_d = task_q + TaskCntW'(1);
      end else begin
        task_d = '0;
        unique case (speed_q)
          2'd1:    duty_d = 7'({gear_q, 4'd0} + {gear_q, 2'd0}) - {2'd0, mod20(duty_q + 7'd1)};
          2'd2:    duty_d = 7'({gear_q, 4'd0} + {gear_q, 2'd0});
          2'd3:    duty_d = 7'({gear_q, 2'd0} + gear_q);
          default: duty_d = duty_q;
        endcase
        if (duty_d > DutyMax) begin
          duty_d = DutyMax;
        end
        deg_d = deg_new;
        if (deg_new > high_q) begin
          alarm_d  = ALARM_HIGH;
          paused_d = 1'b1;
        end else if (deg_new < low_q) begin
          alarm_d  = ALARM_LOW;
          paused_d = 1'b1;
        end else begin
          alarm_d  = ALARM_NONE;
          buzz_d   = 1'b1;
          paused_d = 1'b0;
        end
        if (cd_q != 7'd0) begin
          if (half_q < 2'd2) begin
            half_d = half_q + 2'd1;
          end else begin
            half_d = 2'd0;
            if (cd_q > 7'd1) begin
              cd_d = cd_q - 7'd1;
            end else begin
              started_d = 1'b0;
              cd_d      = 7'd0;
              swon_d    = 1'b0;
            end
          end
        end
        if (auto_q) begin
          priority if (deg_new < b1_q) begin
            gear_d = 3'd1;
          end else if (deg_new < b2_q) begin
            gear_d = 3'd2;
          end else if (deg_new < b3_q) begin
            gear_d = 3'd3;
          end else begin
            gear_d = 3'd4;
          end
        end
      end

      if (alarm_d != ALARM_NONE) begin
        beep_d = beep_q + 8'd1;
        if ((alarm_d == ALARM_HIGH && beep_d >= BeepHigh) ||
            (alarm_d == ALARM_LOW && beep_d >= BeepLow)) begin
          buzz_d = ~buzz_d;
          beep_d = 8'd0;
        end
      end
    end else begin
      unique case (key_e'(key_code_i))
        KEY_GEAR1, KEY_GEAR2, KEY_GEAR3, KEY_GEAR4: begin
          gear_d = {1'b0, key_code_i[1:0]} + 3'd1;
          auto_d = 1'b0;
        end
        KEY_SPEED1, KEY_SPEED2, KEY_SPEED3: begin
          speed_d = 2'(key_code_i - 4'd3);
          auto_d  = 1'b0;
        end
        KEY_TIMER_ADD: begin
          if (cd_q < TimerCeiling) begin
            cd_d = cd_q + TimerStep;
          end
        end
        KEY_SWING: swon_d = ~swon_q;
        KEY_START: started_d = 1'b1;
        KEY_STOP: begin
          started_d = 1'b0;
          swon_d    = 1'b0;
          cd_d      = 7'd0;
          auto_d    = 1'b0;
        end
        KEY_AUTO: auto_d = ~auto_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= AlarmHighReset;
      low_q  <= AlarmLowReset;
      b1_q   <= BandOneReset;
      b2_q   <= BandTwoReset;
      b3_q   <= BandThreeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ALARM_HIGH: high_q <= cfg_data_i;
        REG_ALARM_LOW:  low_q  <= cfg_data_i;
        REG_BAND_ONE:   b1_q   <= cfg_data_i;
        REG_BAND_TWO:   b2_q   <= cfg_data_i;
        REG_BAND_THREE: b3_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q     <= '0;
      sph_q     <= '0;
      flip_q    <= '0;
      sduty_q   <= 2'd1;
      task_q    <= '0;
      half_q    <= '0;
      duty_q    <= DutyReset;
      gear_q    <= 3'd1;
      speed_q   <= 2'd1;
      cd_q      <= '0;
      started_q <= 1'b0;
      swon_q    <= 1'b0;
      auto_q    <= 1'b0;
      paused_q  <= 1'b0;
      alarm_q   <= ALARM_NONE;
      beep_q    <= '0;
      deg_q     <= '0;
      heat_q    <= 1'b1;
      swp_q     <= 1'b0;
      buzz_q    <= 1'b1;
    end else if (step_i) begin
      pwm_q     <= pwm_d;
      sph_q     <= sph_d;
      flip_q    <= flip_d;
      sduty_q   <= sduty_d;
      task_q    <= task_d;
      half_q    <= half_d;
      duty_q    <= duty_d;
      gear_q    <= gear_d;
      speed_q   <= speed_d;
      cd_q      <= cd_d;
      started_q <= started_d;
      swon_q    <= swon_d;
      auto_q    <= auto_d;
      paused_q  <= paused_d;
      alarm_q   <= alarm_d;
      beep_q    <= beep_d;
      deg_q     <= deg_d;
      heat_q    <= heat_d;
      swp_q     <= swp_d;
      buzz_q    <= buzz_d;
    end
  end

  always_comb begin
    result_o.heater_drive  = heat_d;
    result_o.swing_drive   = swp_d;
    result_o.buzzer_drive  = buzz_d;
    result_o.gear_level    = gear_d;
    result_o.speed_level   = speed_d;
    result_o.minutes_left  = cd_d;
    result_o.alarm_kind    = alarm_d;
    result_o.temperature_c = deg_d;
    result_o.running       = started_d;
  end

endmodule

FILE: verif/fan_heater_status_checker.sv
// ----------------------------------------------------------------------------
// fan_heater_status_checker
// Watches the tick/key channel, the status channel and the threshold writes
// of the fan heater tick controller. It keeps its own copy of the controller
// state and thresholds, works out the status beat that every accepted input
// beat must produce, and compares each status beat field by field with the
// oldest outstanding prediction. Mismatches, outstanding predictions and a
// few counts of what the run reached are handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_heater_status_checker import fhtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // [3:0] key_code, [15:4] sensor_word
  input  logic [15:0]         s_axis_tdata,
  // [0] op
  input  logic [0:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] heater_drive, [1] swing_drive, [2] buzzer_drive, [5:3] gear_level,
  // [7:6] speed_level, [14:8] minutes_left, [16:15] alarm_kind,
  // [24:17] temperature_c, [25] running
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output int                  mismatches_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  tasks_o,
  output int                  alarm_tasks_o,
  output int                  expiries_o,
  output int                  flips_o
);

  localparam logic [6:0] MinutesMax = 7'd99;
  localparam int unsigned ReportLimit = 20;

  logic signed [7:0] thr_high, thr_low, band_one, band_two, band_three;

  logic [6:0]        pwm_ph;
  logic [4:0]        sw_ph;
  logic [10:0]       flip_cnt;
  logic [1:0]        sw_duty;
  logic [8:0]        task_cnt;
  logic [1:0]        third_cnt;
  logic [6:0]        duty;
  logic [2:0]        gear;
  logic [1:0]        speed;
  logic [6:0]        minutes;
  logic              started, swing_en, auto_en, paused;
  alarm_e            alarm;
  logic [7:0]        beep;
  logic signed [7:0] degrees;
  logic              heat_pin, swing_pin, buzz_pin;

  result_t status_due[$];

  task automatic reset_state();
    thr_high   = AlarmHighReset;
    thr_low    = AlarmLowReset;
    band_one   = BandOneReset;
    band_two   = BandTwoReset;
    band_three = BandThreeReset;
    pwm_ph     = '0;
    sw_ph      = '0;
    flip_cnt   = '0;
    sw_duty    = 2'd1;
    task_cnt   = '0;
    third_cnt  = '0;
    duty       = DutyReset;
    gear       = 3'd1;
    speed      = 2'd1;
    minutes    = '0;
    started    = 1'b0;
    swing_en   = 1'b0;
    auto_en    = 1'b0;
    paused     = 1'b0;
    alarm      = ALARM_NONE;
    beep       = '0;
    degrees    = '0;
    heat_pin   = 1'b1;
    swing_pin  = 1'b0;
    buzz_pin   = 1'b1;
    status_due.delete();
    mismatches_o  = 0;
    pending_o     = 0;
    checked_o     = 0;
    tasks_o       = 0;
    alarm_tasks_o = 0;
    expiries_o    = 0;
    flips_o       = 0;
  endtask

  task automatic apply_threshold(input logic [2:0] idx, input logic [7:0] val);
    case (cfg_reg_e'(idx))
      REG_ALARM_HIGH: thr_high   = val;
      REG_ALARM_LOW:  thr_low    = val;
      REG_BAND_ONE:   band_one   = val;
      REG_BAND_TWO:   band_two   = val;
      REG_BAND_THREE: band_three = val;
      default: ;
    endcase
  endtask

  task automatic run_task(input logic [11:0] sensor);
    int d;
    int w;
    int mag;
    int temp;
    d = int'(duty);
    if (speed == 2'd1) begin
      d = int'(gear) * 20 - ((d + 1) % 20);
    end else if (speed == 2'd2) begin
      d = int'(gear) * 20;
    end else if (speed == 2'd3) begin
      d = int'(gear) * 5;
    end
    if (d > int'(DutyMax)) begin
      d = int'(DutyMax);
    end
    duty = 7'(d);

    w = int'($signed(sensor));
    mag = (w < 0 ? -w : w) / 16;
    temp = (w < 0) ? -mag : mag;
    degrees = 8'(temp);

    if (temp > int'(thr_high)) begin
      alarm = ALARM_HIGH;
      paused = 1'b1;
    end else if (temp < int'(thr_low)) begin
      alarm = ALARM_LOW;
      paused = 1'b1;
    end else begin
      alarm = ALARM_NONE;
      buzz_pin = 1'b1;
      paused = 1'b0;
    end

    if (minutes != '0) begin
      if (third_cnt < 2'd2) begin
        third_cnt = third_cnt + 2'd1;
      end else begin
        third_cnt = '0;
        if (minutes > 7'd1) begin
          minutes = minutes - 7'd1;
        end else begin
          started = 1'b0;
          minutes = '0;
          swing_en = 1'b0;
          expiries_o++;
        end
      end
    end

    if (auto_en) begin
      if (temp < int'(band_one)) begin
        gear = 3'd1;
      end else if (temp < int'(band_two)) begin
        gear = 3'd2;
      end else if (temp < int'(band_three)) begin
        gear = 3'd3;
      end else begin
        gear = 3'd4;
      end
    end

    tasks_o++;
    if (alarm != ALARM_NONE) begin
      alarm_tasks_o++;
    end
  endtask

  task automatic apply_tick(input logic [11:0] sensor);
    if (!paused) begin
      if (started) begin
        pwm_ph = (pwm_ph < PwmLast) ? pwm_ph + 7'd1 : '0;
        heat_pin = (pwm_ph < duty) ? 1'b0 : 1'b1;
        sw_ph = (sw_ph < SwingLast) ? sw_ph + 5'd1 : '0;
        swing_pin = (5'(sw_duty) > sw_ph) ? 1'b1 : 1'b0;
        if (swing_en) begin
          if (int'(flip_cnt) < int'(SWING_FLIP_TICKS)) begin
            flip_cnt = flip_cnt + 11'd1;
          end else begin
            flip_cnt = '0;
            sw_duty = (sw_duty == 2'd1) ? 2'd2 : 2'd1;
            flips_o++;
          end
        end
      end else begin
        swing_en = 1'b0;
        heat_pin = 1'b1;
      end
    end

    if (int'(task_cnt) < int'(TASK_TICKS)) begin
      task_cnt = task_cnt + 9'd1;
    end else begin
      task_cnt = '0;
      run_task(sensor);
    end

    if (alarm != ALARM_NONE) begin
      beep = beep + 8'd1;
      if (alarm == ALARM_HIGH && beep >= BeepHigh) begin
        buzz_pin = ~buzz_pin;
        beep = '0;
      end else if (alarm == ALARM_LOW && beep >= BeepLow) begin
        buzz_pin = ~buzz_pin;
        beep = '0;
      end
    end
  endtask

  task automatic apply_key(input logic [3:0] k);
    case (key_e'(k))
      KEY_GEAR1, KEY_GEAR2, KEY_GEAR3, KEY_GEAR4: begin
        gear = 3'(k) + 3'd1;
        auto_en = 1'b0;
      end
      KEY_SPEED1, KEY_SPEED2, KEY_SPEED3: begin
        speed = 2'(k - 4'(KEY_SPEED1) + 4'd1);
        auto_en = 1'b0;
      end
      KEY_TIMER_ADD: begin
        if (minutes < TimerCeiling) begin
          minutes = minutes + TimerStep;
        end
        if (minutes > MinutesMax) begin
          minutes = MinutesMax;
        end
      end
      KEY_SWING: swing_en = ~swing_en;
      KEY_START: started = 1'b1;
      KEY_STOP: begin
        started = 1'b0;
        swing_en = 1'b0;
        minutes = '0;
        auto_en = 1'b0;
      end
      KEY_AUTO: auto_en = ~auto_en;
      default: ;
    endcase
  endtask

  function automatic result_t predict_status();
    result_t r;
    r.heater_drive  = heat_pin;
    r.swing_drive   = swing_pin;
    r.buzzer_drive  = buzz_pin;
    r.gear_level    = gear;
    r.speed_level   = speed;
    r.minutes_left  = minutes;
    r.alarm_kind    = alarm;
    r.temperature_c = degrees;
    r.running       = started;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches_o++;
    if (mismatches_o <= ReportLimit) begin
      $display("%0t: status beat %0d, %s is %0d, expected %0d", $time, checked_o, what,
               got, want);
    end
  endtask

  task automatic check_status(input logic [ResultW-1:0] raw);
    result_t got;
    result_t want;
    got = result_t'(raw);
    if (status_due.size() == 0) begin
      report_mismatch("beat with nothing outstanding", 1, 0);
    end else begin
      want = status_due.pop_front();
      if (got.heater_drive != want.heater_drive)
        report_mismatch("heater_drive", got.heater_drive, want.heater_drive);
      if (got.swing_drive != want.swing_drive)
        report_mismatch("swing_drive", got.swing_drive, want.swing_drive);
      if (got.buzzer_drive != want.buzzer_drive)
        report_mismatch("buzzer_drive", got.buzzer_drive, want.buzzer_drive);
      if (got.gear_level != want.gear_level)
        report_mismatch("gear_level", got.gear_level, want.gear_level);
      if (got.speed_level != want.speed_level)
        report_mismatch("speed_level", got.speed_level, want.speed_level);
      if (got.minutes_left != want.minutes_left)
        report_mismatch("minutes_left", got.minutes_left, want.minutes_left);
      if (got.alarm_kind != want.alarm_kind)
        report_mismatch("alarm_kind", got.alarm_kind, want.alarm_kind);
      if (got.temperature_c != want.temperature_c)
        report_mismatch("temperature_c", int'(got.temperature_c),
                        int'(want.temperature_c));
      if (got.running != want.running)
        report_mismatch("running", got.running, want.running);
    end
    checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_state();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_threshold(cfg_index_i, cfg_data_i);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_status(m_axis_tdata[ResultW-1:0]);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == OP_TICK) begin
          apply_tick(s_axis_tdata[15:4]);
        end else begin
          apply_key(s_axis_tdata[3:0]);
        end
        status_due.push_back(predict_status());
      end
      pending_o = status_due.size();
    end
  end

endmodule

FILE: verif/tb_fan_heater_tick_controller.sv
// ----------------------------------------------------------------------------
// tb_fan_heater_tick_controller
// Stimulus and verdict for the fan heater tick controller.
//
// After reset a short directed sequence presses every key code, including
// the undefined ones, and drives the countdown up to its ceiling. A longer
// run then starts the fan with swing and a countdown and ticks with sensor
// words inside the alarm band, so that the heater and swing PWM advance.
// Further phases rewrite the five thresholds (extremes and random values)
// and send a random mix of ticks and keys with sensor words near the
// thresholds; the first duty task falls in the phase whose thresholds force
// an alarm, so the pause and the buzzer toggling are exercised after it.
// Both channels idle at random, apart from one long stretch, and the sender
// drains the controller before every threshold write and once inside each
// phase. The checker beside the controller does all the prediction and
// comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fan_heater_tick_controller;
  import fhtc_pkg::*;

  localparam int IdlePct        = 24;
  localparam int PhaseItems     = 100;
  localparam int CountdownItems = 400;
  localparam int CycleLimit     = 500000;
  localparam logic OpKey        = ~OP_TICK;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [15:0]         s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic [2:0]          cfg_index_i   = '0;
  logic [7:0]          cfg_data_i    = '0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_ready_o;

  bit                steady = 1'b0;
  int                cycles = 0;
  int                beats_sent = 0;
  logic signed [7:0] thr [5];

  int mismatches, pending, checked, tasks_run, alarm_tasks, expiries, flips;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fan_heater_tick_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  fan_heater_status_checker status_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked),
    .tasks_o       (tasks_run),
    .alarm_tasks_o (alarm_tasks),
    .expiries_o    (expiries),
    .flips_o       (flips)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_beat(input logic op, input logic [3:0] key, input logic [11:0] sensor);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {sensor, key};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_key(input logic [3:0] key);
    send_beat(OpKey, key, 12'($urandom));
  endtask

  task automatic send_tick(input logic [11:0] sensor);
    send_beat(OP_TICK, 4'($urandom), sensor);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic signed [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    thr[idx] = val;
  endtask

  task automatic set_thresholds(input logic signed [7:0] high, input logic signed [7:0] low,
                                input logic signed [7:0] one, input logic signed [7:0] two,
                                input logic signed [7:0] three);
    write_reg(REG_ALARM_HIGH, high);
    write_reg(REG_ALARM_LOW, low);
    write_reg(REG_BAND_ONE, one);
    write_reg(REG_BAND_TWO, two);
    write_reg(REG_BAND_THREE, three);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [7:0] random_threshold();
    return 8'(int'($urandom_range(180)) - 55);
  endfunction

  function automatic logic [11:0] sensor_from_degrees(input int deg);
    int frac;
    frac = $urandom_range(15);
    return 12'((deg < 0) ? deg * 16 - frac : deg * 16 + frac);
  endfunction

  function automatic logic [11:0] pick_sensor();
    logic [11:0] word;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: word = 12'h800;
          1: word = 12'h7FF;
          2: word = 12'hFF1;
          default: word = 12'hFF0;
        endcase
      end
      1: word = 12'($urandom);
      default: begin
        word = sensor_from_degrees(int'(thr[$urandom_range(4)]) +
                                   int'($urandom_range(4)) - 2);
      end
    endcase
    return word;
  endfunction

  function automatic logic [3:0] pick_key();
    logic [3:0] key;
    case ($urandom_range(19))
      0, 1, 2, 3: key = KEY_START;
      4, 5, 6, 7: key = 4'(KEY_GEAR1) + 4'($urandom_range(3));
      8, 9, 10:   key = 4'(KEY_SPEED1) + 4'($urandom_range(2));
      11, 18:     key = KEY_TIMER_ADD;
      12, 13, 19: key = KEY_SWING;
      14, 17:     key = KEY_AUTO;
      15:         key = KEY_STOP;
      default:    key = 4'($urandom_range(15));
    endcase
    return key;
  endfunction

  task automatic random_mix(input int n);
    int hold_at;
    hold_at = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) begin
        drain();
      end
      if ($urandom_range(99) < 86) begin
        send_tick(pick_sensor());
      end else begin
        send_key(pick_key());
      end
    end
    drain();
  endtask

  task automatic countdown_run();
    send_key(KEY_STOP);
    send_key(KEY_START);
    send_key(KEY_SWING);
    send_key(KEY_TIMER_ADD);
    for (int i = 0; i < CountdownItems; i++) begin
      if (i == CountdownItems / 4) begin
        drain();
      end
      if (i == CountdownItems / 2) begin
        steady <= 1'b0;
      end
      case ($urandom_range(49))
        0: send_key(4'(KEY_GEAR1) + 4'($urandom_range(3)));
        1: send_key(4'(KEY_SPEED1) + 4'($urandom_range(2)));
        2: send_key(KEY_AUTO);
        3: send_tick(pick_sensor());
        default: begin
          send_tick(sensor_from_degrees($urandom_range(int'(thr[REG_ALARM_HIGH]) - 1,
                                                       int'(thr[REG_ALARM_LOW]) + 1)));
        end
      endcase
    end
    drain();
  endtask

  initial begin
    thr[REG_ALARM_HIGH] = AlarmHighReset;
    thr[REG_ALARM_LOW]  = AlarmLowReset;
    thr[REG_BAND_ONE]   = BandOneReset;
    thr[REG_BAND_TWO]   = BandTwoReset;
    thr[REG_BAND_THREE] = BandThreeReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < 16; k++) begin
      send_key(4'(k));
    end
    send_key(KEY_START);
    repeat (10) send_key(KEY_TIMER_ADD);
    drain();

    steady <= 1'b1;
    countdown_run();

    set_thresholds(8'sd125, -8'sd55, -8'sd55, 8'sd0, 8'sd125);
    random_mix(PhaseItems);
    set_thresholds(-8'sd55, 8'sd125, 8'sd125, -8'sd55, -8'sd55);
    random_mix(PhaseItems);
    repeat (3) begin
      set_thresholds(random_threshold(), random_threshold(), random_threshold(),
                     random_threshold(), random_threshold());
      random_mix(PhaseItems);
    end
    repeat (5) @(posedge clk_i);

    $display("Sent %0d beats, checked %0d status beats in %0d cycles.", beats_sent,
             checked, cycles);
    $display("Duty tasks %0d (with alarm %0d), swing flips %0d, countdown expiries %0d.",
             tasks_run, alarm_tasks, flips, expiries);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
